FILE: rtl/chacha_pkg.sv
// Shared types, constants and register indices of the ChaCha20 keystream generator.
`default_nettype none

package chacha_pkg;

   localparam int NUM_WORDS      = 16;
   localparam int WORD_W         = 32;
   localparam int WORD_IDX_W     = 4;
   localparam int CFG_COUNT      = 7;
   localparam int CFG_IDX_W      = 3;
   localparam int CFG_W          = 64;
   localparam int ROUNDS_DEFAULT = 20;

   // Request kinds carried on the request tuser bit.
   localparam logic FUNC_BLOCK = 1'b0;
   localparam logic FUNC_LOAD  = 1'b1;

   // Configuration register indices.
   localparam logic [CFG_IDX_W-1:0] CSR_CONST_LO = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_CONST_HI = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_KEY_0    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CSR_KEY_1    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CSR_KEY_2    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CSR_KEY_3    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CSR_NONCE    = 3'd6;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = 4'(NUM_WORDS - 1);

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_EMIT
   } state_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic                  state_load;
      logic                  round_step;
      logic                  round_diag;
      logic                  emit;
      logic [WORD_IDX_W-1:0] emit_index;
      logic                  emit_last;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/chacha_round.sv
// One ChaCha round over the whole state: four quarter rounds, column or diagonal.
`default_nettype none

module chacha_round
   import chacha_pkg::*;
(
   input  words_type words_in,
   input  logic      diag,
   output words_type words_out
);

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   function automatic words_type quarter(input words_type x,
                                         input logic [WORD_IDX_W-1:0] a,
                                         input logic [WORD_IDX_W-1:0] b,
                                         input logic [WORD_IDX_W-1:0] c,
                                         input logic [WORD_IDX_W-1:0] d);
      words_type y;
      y    = x;
      y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 16);
      y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 12);
      y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 8);
      y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 7);
      return y;
   endfunction

   // The four quarter rounds of one round touch disjoint words, so they run side by side.
   always_comb begin
      words_type w;
      w = words_in;
      for (int i = 0; i < 4; i++) begin
         if (!diag) begin
            w = quarter(w, 4'(i), 4'(i + 4), 4'(i + 8), 4'(i + 12));
         end else begin
            w = quarter(w, 4'(i), 4'(4 + ((i + 1) & 3)), 4'(8 + ((i + 2) & 3)),
                        4'(12 + ((i + 3) & 3)));
         end
      end
      words_out = w;
   end

endmodule

`default_nettype wire

FILE: rtl/chacha_ctrl.sv
// Sequencer: round counting, word emission and request acceptance.
`default_nettype none

module chacha_ctrl
   import chacha_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     out_free,
   output logic     idle,
   output ctrl_type ctrl
);

   localparam int RND_W = $clog2(ROUNDS);
   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

   state_type             state_ff, state_in;
   logic [RND_W-1:0]      round_ff, round_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_ROUND;
         ST_ROUND: if (round_ff == LAST_ROUND) state_in = ST_EMIT;
         ST_EMIT:  if (out_free && word_ff == LAST_WORD_IDX) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idle            = 1'b0;
      ctrl.state_load = 1'b0;
      ctrl.round_step = 1'b0;
      ctrl.emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idle            = 1'b1;
            ctrl.state_load = start;
         end
         ST_ROUND: ctrl.round_step = 1'b1;
         ST_EMIT:  ctrl.emit       = out_free;
         default:  idle            = 1'b0;
      endcase
      ctrl.round_diag = round_ff[0];
      ctrl.emit_index = word_ff;
      ctrl.emit_last  = word_ff == LAST_WORD_IDX;
   end

   always_comb begin
      round_in = round_ff;
      word_in  = word_ff;
      if (ctrl.state_load) begin
         round_in = '0;
         word_in  = '0;
      end else begin
         if (ctrl.round_step) round_in = round_ff + 1'b1;
         if (ctrl.emit)       word_in  = word_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/chacha20_keystream_generator_top.sv
// Top level of the ChaCha20 keystream generator: registers, state and stream ports.
`default_nettype none

// ChaCha20 keystream generator. Constants, key and nonce are written through the csr port
// (index 0/1 constant words 0..3, 2..5 key words 4..11, 6 nonce words 14..15, lower word in
// the low half; index 7 is ignored); the user must write them only while the block is idle,
// which the block itself does not enforce. A request transaction with tuser FUNC_LOAD sets
// the 64-bit block counter from tdata and leaves req_tready high. A request with tuser
// FUNC_BLOCK runs ROUNDS rounds, one per cycle through a single shared round unit, and
// then emits the sixteen keystream words on the response stream, one per cycle while the
// consumer keeps tready high, with tlast on word 15. The counter then advances by one and
// wraps from all ones to zero. A block request therefore holds req_tready low through its
// rounds and the emission of all sixteen words; the last word may still wait in the
// output register while the next request is accepted.

module chacha20_keystream_generator_top
   import chacha_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   // Request stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [63:0] counter_value
   input  logic                 req_tuser,   // [0] func
   // Response stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [3:0] word_index, [35:4] word_value, zero above
   output logic                 rsp_tlast,   // last_word
   // Configuration writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic [CFG_W-1:0]      cfg_ff [CFG_COUNT];
   logic [63:0]           counter_ff, counter_in;
   words_type             working_ff, working_in;
   words_type             orig;
   words_type             round_out;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [WORD_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  idle;
   logic                  req_fire;
   logic                  start;
   logic                  load;
   logic                  out_free;
   ctrl_type              ctrl;

   // Configuration writes are always taken; writes beyond the register list are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_valid && csr_index < CFG_IDX_W'(CFG_COUNT)) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_fire && req_tuser == FUNC_BLOCK;
   assign load       = req_fire && req_tuser == FUNC_LOAD;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The starting state, rebuilt from registers and counter, is also the feed-forward term.
   // The counter holds during a block; the user must not write registers then (unenforced).
   always_comb begin
      orig[0]  = cfg_ff[CSR_CONST_LO][31:0];
      orig[1]  = cfg_ff[CSR_CONST_LO][63:32];
      orig[2]  = cfg_ff[CSR_CONST_HI][31:0];
      orig[3]  = cfg_ff[CSR_CONST_HI][63:32];
      orig[4]  = cfg_ff[CSR_KEY_0][31:0];
      orig[5]  = cfg_ff[CSR_KEY_0][63:32];
      orig[6]  = cfg_ff[CSR_KEY_1][31:0];
      orig[7]  = cfg_ff[CSR_KEY_1][63:32];
      orig[8]  = cfg_ff[CSR_KEY_2][31:0];
      orig[9]  = cfg_ff[CSR_KEY_2][63:32];
      orig[10] = cfg_ff[CSR_KEY_3][31:0];
      orig[11] = cfg_ff[CSR_KEY_3][63:32];
      orig[12] = counter_ff[31:0];
      orig[13] = counter_ff[63:32];
      orig[14] = cfg_ff[CSR_NONCE][31:0];
      orig[15] = cfg_ff[CSR_NONCE][63:32];
   end

   chacha_ctrl #(
      .ROUNDS (ROUNDS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .idle     (idle),
      .ctrl     (ctrl)
   );

   chacha_round u_round (
      .words_in  (working_ff),
      .diag      (ctrl.round_diag),
      .words_out (round_out)
   );

   // Working state: loaded at the start of a block, then one round per cycle.
   always_comb begin
      working_in = working_ff;
      if (ctrl.state_load) begin
         working_in = orig;
      end else if (ctrl.round_step) begin
         working_in = round_out;
      end
   end

   always_ff @(posedge clock) begin
      working_ff <= working_in;
   end

   // Block counter: set by a load transaction, advanced once the last word is issued.
   always_comb begin
      counter_in = counter_ff;
      if (load) begin
         counter_in = req_tdata;
      end else if (ctrl.emit && ctrl.emit_last) begin
         counter_in = counter_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   // Output register: a new word enters whenever the previous one has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = ctrl.emit_index;
         rsp_value_in = working_ff[ctrl.emit_index] + orig[ctrl.emit_index];
         rsp_last_in  = ctrl.emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_value_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_last_is_word_15: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_index_ff == LAST_WORD_IDX)
      else $error("tlast on a word other than the last of the block");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("request accepted while a block is in progress");

   a_counter_load: assert property (@(posedge clock) disable iff (reset)
      load |=> counter_ff == $past(req_tdata))
      else $error("block counter not loaded from the request");

   a_counter_advance: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit && ctrl.emit_last |=> counter_ff == $past(counter_ff) + 64'd1)
      else $error("block counter did not advance after the last word");
`endif

endmodule

`default_nettype wire

FILE: verif/chacha20_keystream_generator_top_test.sv
// Self-checking testbench for the ChaCha20 keystream generator, with its own block predictor.

module chacha20_keystream_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import chacha_pkg::*;

   // The block is built with its default round count, and the predictor uses the same.
   localparam int ROUNDS = ROUNDS_DEFAULT;
   localparam int RESET_CYCLES = 12;
   // Quiet time after the last keystream word before the block counts as idle. A load
   // produces no word, and it is complete once it has been accepted.
   localparam int SETTLE_CYCLES = ROUNDS + 44;
   localparam int CYCLE_LIMIT = 400000;
   // Length of the deliberate receiver hold-off that backs the block up.
   localparam int STALL_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 31;
   // Mismatches beyond this are still counted, but no longer printed.
   localparam int MAX_PRINTED = 100;
   // Index 7 has no register behind it; writes to it must be ignored.
   localparam logic [CFG_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [CFG_W-1:0] ALL_ONES = '1;

   // One keystream word as it should appear on the response stream.
   typedef struct packed {
      logic [WORD_IDX_W-1:0] index;
      logic [WORD_W-1:0]     value;
      logic                  last;
   } keystream_word_type;

   // The scoreboard keeps its own copy of the configuration registers and of the block
   // counter. Every accepted block request is expanded straight away into the sixteen
   // words that the block must emit, and these are queued in order.
   class keystream_scoreboard;
      int rounds;
      int errors;
      logic [CFG_W-1:0] regs [CFG_COUNT];
      logic [63:0] block_count;
      keystream_word_type expected_words[$];

      function new(int round_count);
         rounds = round_count;
         errors = 0;
         block_count = '0;
         foreach (regs[i]) regs[i] = '0;
      endfunction

      function void write_register(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_W-1:0] data);
         if (reg_index < CFG_COUNT) regs[reg_index] = data;
      endfunction

      function logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int s);
         return (v << s) | (v >> (WORD_W - s));
      endfunction

      function words_type quarter_round(words_type x, int a, int b, int c, int d);
         x[a] = x[a] + x[b];
         x[d] = rotl(x[d] ^ x[a], 16);
         x[c] = x[c] + x[d];
         x[b] = rotl(x[b] ^ x[c], 12);
         x[a] = x[a] + x[b];
         x[d] = rotl(x[d] ^ x[a], 8);
         x[c] = x[c] + x[d];
         x[b] = rotl(x[b] ^ x[c], 7);
         return x;
      endfunction

      function void note_request(logic func, logic [63:0] counter_value);
         words_type start_words;
         words_type mix;
         keystream_word_type word;
         if (func == FUNC_LOAD) begin
            block_count = counter_value;
         end else begin
            // Registers 0 to 5 fill words 0 to 11, lower word in the low half.
            for (int i = 0; i < 6; i++) begin
               start_words[2*i]   = regs[i][31:0];
               start_words[2*i+1] = regs[i][63:32];
            end
            start_words[12] = block_count[31:0];
            start_words[13] = block_count[63:32];
            start_words[14] = regs[CSR_NONCE][31:0];
            start_words[15] = regs[CSR_NONCE][63:32];
            mix = start_words;
            // Even rounds work on columns, odd rounds on diagonals.
            for (int r = 0; r < rounds; r++) begin
               for (int j = 0; j < 4; j++) begin
                  if (r % 2 == 0) begin
                     mix = quarter_round(mix, j, j + 4, j + 8, j + 12);
                  end else begin
                     mix = quarter_round(mix, j, 4 + (j + 1) % 4, 8 + (j + 2) % 4,
                                         12 + (j + 3) % 4);
                  end
               end
            end
            for (int k = 0; k < NUM_WORDS; k++) begin
               word.index = WORD_IDX_W'(k);
               word.value = mix[k] + start_words[k];
               word.last  = (word.index == LAST_WORD_IDX);
               expected_words.push_back(word);
            end
            block_count = block_count + 64'd1;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_word(logic [39:0] data, logic last);
         keystream_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("keystream word %h arrived with none expected", data));
         end else begin
            want = expected_words.pop_front();
            if (data[3:0] !== want.index)
               report($sformatf("word index %0d, expected %0d", data[3:0], want.index));
            if (data[35:4] !== want.value)
               report($sformatf("word %0d value %h, expected %h", want.index, data[35:4],
                                want.value));
            if (last !== want.last)
               report($sformatf("word %0d tlast %b, expected %b", want.index, last, want.last));
            if (data[39:36] !== 4'd0)
               report($sformatf("word %0d padding bits %b are not zero", want.index,
                                data[39:36]));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;   // [63:0] counter_value
   logic                 req_tuser = FUNC_BLOCK;   // [0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;   // [3:0] word_index, [35:4] word_value, zero above
   logic                 rsp_tlast;   // last_word
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   // Percentages of cycles in which the request side holds back and the response side
   // withholds tready. The main sequence changes them between phases.
   int sender_idle_pct = 21;
   int receiver_idle_pct = 78;
   // The main sequence asks for the long hold-off; the receiver process runs it once.
   bit stall_requested = 1'b0;
   bit stall_taken = 1'b0;
   int stall_left = 0;
   int unsigned cycle_count = 0;
   keystream_scoreboard scoreboard;

   chacha20_keystream_generator_top #(
      .ROUNDS(ROUNDS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung handshake or a lost keystream word ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side. tready changes only on the falling edge. Once asked, it holds tready
   // low for a long stretch, so that the output register stays full, the block cannot
   // finish its current request and the request side sees tready low for a long time.
   always @(negedge clock) begin
      if (stall_requested && !stall_taken) begin
         stall_taken = 1'b1;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Every response transaction is checked at the rising edge at which it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) scoreboard.check_word(rsp_tdata, rsp_tlast);
   end

   // Offers one request and returns right after the edge at which it was accepted, so
   // that a following call can keep tvalid high without a gap.
   task automatic send_request(logic func, logic [63:0] counter_value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = counter_value;
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(func, counter_value);
   endtask

   // Stops offering requests, waits for every expected keystream word and then for a
   // further quiet time, so that the block is certainly idle afterwards.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (scoreboard.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CFG_IDX_W-1:0] reg_index, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = reg_index;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_register(reg_index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [63:0] random_dword();
      return {$urandom, $urandom};
   endfunction

   // Writes every register with random content, a quarter of them all zeros and a
   // quarter all ones, and now and then also the unused index.
   task automatic write_random_settings();
      logic [CFG_W-1:0] data;
      for (int i = 0; i < CFG_COUNT; i++) begin
         case ($urandom_range(3))
            0: data = '0;
            1: data = ALL_ONES;
            default: data = random_dword();
         endcase
         csr_write(CFG_IDX_W'(i), data);
      end
      if ($urandom_range(1) == 1) csr_write(CSR_UNUSED, random_dword());
   endtask

   initial begin
      logic [63:0] value;
      scoreboard = new(ROUNDS);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, first with the registers as reset left them (all zero).
      // A block request ignores its counter field, so it carries a random one here.
      send_request(FUNC_BLOCK, random_dword());
      // The counter wraps from all ones back to zero.
      send_request(FUNC_LOAD, ALL_ONES);
      send_request(FUNC_BLOCK, random_dword());
      send_request(FUNC_BLOCK, '0);
      // Word 12 at all ones carries into word 13 when the counter advances.
      send_request(FUNC_LOAD, 64'h0000_0000_FFFF_FFFF);
      send_request(FUNC_BLOCK, ALL_ONES);
      send_request(FUNC_BLOCK, random_dword());

      // All registers at all ones; a write to the unused index must change nothing.
      wait_idle();
      for (int i = 0; i < CFG_COUNT; i++) csr_write(CFG_IDX_W'(i), ALL_ONES);
      csr_write(CSR_UNUSED, random_dword());
      send_request(FUNC_LOAD, '0);
      send_request(FUNC_BLOCK, ALL_ONES);
      send_request(FUNC_LOAD, random_dword());
      send_request(FUNC_BLOCK, random_dword());

      // The usual constants and the byte-counting key of the published test vector.
      wait_idle();
      csr_write(CSR_CONST_LO, 64'h3320_646E_6170_7865);
      csr_write(CSR_CONST_HI, 64'h6B20_6574_7962_2D32);
      csr_write(CSR_KEY_0, 64'h0706_0504_0302_0100);
      csr_write(CSR_KEY_1, 64'h0F0E_0D0C_0B0A_0908);
      csr_write(CSR_KEY_2, 64'h1716_1514_1312_1110);
      csr_write(CSR_KEY_3, 64'h1F1E_1D1C_1B1A_1918);
      csr_write(CSR_NONCE, 64'h4A00_0000_0000_0000);
      send_request(FUNC_LOAD, 64'd1);
      send_request(FUNC_BLOCK, '0);
      send_request(FUNC_BLOCK, random_dword());
      send_request(FUNC_LOAD, random_dword());
      send_request(FUNC_BLOCK, random_dword());

      // Random part in three phases: slow receiver, then slow sender, then both at full
      // rate with one long receiver hold-off. Each phase starts from fresh settings.
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               sender_idle_pct = 21;
               receiver_idle_pct = 78;
            end
            1: begin
               sender_idle_pct = 78;
               receiver_idle_pct = 21;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
               stall_requested = 1'b1;
            end
         endcase
         write_random_settings();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            value = random_dword();
            if ($urandom_range(99) < 70) begin
               send_request(FUNC_BLOCK, value);
            end else begin
               // Loads often land near the counter wrap or the carry out of word 12.
               case ($urandom_range(3))
                  0: value = ALL_ONES - 64'($urandom_range(2));
                  1: value[31:0] = 32'hFFFF_FFFF - $urandom_range(2);
                  default: ;
               endcase
               send_request(FUNC_LOAD, value);
            end
         end
      end

      wait_idle();
      if (scoreboard.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/chacha_pkg.sv
rtl/chacha_round.sv
rtl/chacha_ctrl.sv
rtl/chacha20_keystream_generator_top.sv
verif/chacha20_keystream_generator_top_test.sv
